>>> src/binary_to_decimal_ascii_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the binary to decimal ASCII converter.
// The macros sample on clk_i and are disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_ASCII_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BDA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bda_checker: same-cycle property violated");

// Consequent must hold in the cycle after the antecedent.
`define BDA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bda_checker: next-cycle property violated");

`endif

>>> src/bda_pkg.sv
// ---------------------------------------------------------------------------
// bda_pkg
// Types, constants and the power-of-ten table shared by the converter.
// ---------------------------------------------------------------------------
`default_nettype none

package bda_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned CharWidth  = 6;
  localparam int unsigned PosWidth   = 4;
  localparam int unsigned DigitWidth = 4;

  localparam logic [CharWidth-1:0] AsciiZero = 6'd48;
  localparam logic [PosWidth-1:0]  TopPos    = 4'd9;
  localparam logic [PosWidth-1:0]  UnitsPos  = 4'd0;

  typedef enum logic {
    FrontIdle,
    FrontRun
  } front_state_e;

  typedef struct packed {
    logic [CharWidth-1:0] character;
    logic                 last;
  } char_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  function automatic logic [ValueWidth-1:0] pow10(input logic [PosWidth-1:0] pos);
    logic [ValueWidth-1:0] weight;
    case (pos)
      4'd0:    weight = 32'd1;
      4'd1:    weight = 32'd10;
      4'd2:    weight = 32'd100;
      4'd3:    weight = 32'd1000;
      4'd4:    weight = 32'd10000;
      4'd5:    weight = 32'd100000;
      4'd6:    weight = 32'd1000000;
      4'd7:    weight = 32'd10000000;
      4'd8:    weight = 32'd100000000;
      4'd9:    weight = 32'd1000000000;
      default: weight = 32'd1;
    endcase
    return weight;
  endfunction

endpackage

`default_nettype wire

>>> src/bda_front.sv
// ---------------------------------------------------------------------------
// bda_front
// Accepts an item and extracts its decimal digits by repeated subtraction.
// ---------------------------------------------------------------------------
`default_nettype none

module bda_front (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic [bda_pkg::ValueWidth-1:0]        value_i,
  input  wire bda_pkg::queue_stat_t                  stat_i,
  output logic                                       push_o,
  output bda_pkg::char_item_t                        item_o
);

  bda_pkg::front_state_e             state_q, state_d;
  logic [bda_pkg::ValueWidth-1:0]    rest_q;
  logic [bda_pkg::PosWidth-1:0]      pos_q;
  logic [bda_pkg::DigitWidth-1:0]    digit_q;
  logic                              started_q;
  logic [bda_pkg::ValueWidth-1:0]    weight;
  logic                              ge;
  logic                              emit;
  logic                              stall;
  logic                              accept;

  assign weight = bda_pkg::pow10(pos_q);
  assign ge     = (rest_q >= weight);
  assign emit   = !ge && ((digit_q != '0) || started_q || (pos_q == bda_pkg::UnitsPos));
  assign stall  = emit && stat_i.full;
  assign accept = start && (state_q == bda_pkg::FrontIdle);

  always_comb begin
    state_d = state_q;
    case (state_q)
      bda_pkg::FrontIdle: begin
        if (start) begin
          state_d = bda_pkg::FrontRun;
        end
      end
      bda_pkg::FrontRun: begin
        if (!ge && !stall && (pos_q == bda_pkg::UnitsPos)) begin
          state_d = bda_pkg::FrontIdle;
        end
      end
      default: state_d = bda_pkg::FrontIdle;
    endcase
  end

  always_comb begin
    busy   = 1'b0;
    push_o = 1'b0;
    case (state_q)
      bda_pkg::FrontIdle: begin
        busy   = 1'b0;
        push_o = 1'b0;
      end
      bda_pkg::FrontRun: begin
        busy   = 1'b1;
        push_o = emit && !stat_i.full;
      end
      default: begin
        busy   = 1'b0;
        push_o = 1'b0;
      end
    endcase
  end

  assign item_o.character = bda_pkg::AsciiZero + {2'b00, digit_q};
  assign item_o.last      = (pos_q == bda_pkg::UnitsPos);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bda_pkg::FrontIdle;
      pos_q     <= bda_pkg::TopPos;
      digit_q   <= '0;
      started_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        pos_q     <= bda_pkg::TopPos;
        digit_q   <= '0;
        started_q <= 1'b0;
      end else if (state_q == bda_pkg::FrontRun) begin
        if (ge) begin
          digit_q <= digit_q + 4'd1;
        end else if (!stall) begin
          pos_q     <= pos_q - 4'd1;
          digit_q   <= '0;
          started_q <= started_q || (digit_q != '0);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rest_q <= value_i;
    end else if ((state_q == bda_pkg::FrontRun) && ge) begin
      rest_q <= rest_q - weight;
    end
  end

endmodule

`default_nettype wire

>>> src/bda_queue.sv
// ---------------------------------------------------------------------------
// bda_queue
// Small first-in first-out buffer of characters between front and back.
// ---------------------------------------------------------------------------
`default_nettype none

module bda_queue #(
  parameter int unsigned Depth = 4
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire bda_pkg::char_item_t  wdata_i,
  input  wire logic                 pop_i,
  output bda_pkg::char_item_t       rdata_o,
  output bda_pkg::queue_stat_t      stat_o
);

  localparam int unsigned AddrWidth  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CountWidth = $clog2(Depth + 1);
  localparam logic [AddrWidth-1:0]  LastAddr  = AddrWidth'(Depth - 1);
  localparam logic [CountWidth-1:0] FullCount = CountWidth'(Depth);

  bda_pkg::char_item_t     mem_q [Depth];
  logic [AddrWidth-1:0]    wr_ptr_q;
  logic [AddrWidth-1:0]    rd_ptr_q;
  logic [CountWidth-1:0]   count_q;
  logic                    do_push;
  logic                    do_pop;

  assign stat_o.full  = (count_q == FullCount);
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign rdata_o      = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastAddr) ? '0 : wr_ptr_q + AddrWidth'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastAddr) ? '0 : rd_ptr_q + AddrWidth'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CountWidth'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CountWidth'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

>>> src/bda_back.sv
// ---------------------------------------------------------------------------
// bda_back
// Drains the queue and presents one character per cycle with a strobe.
// ---------------------------------------------------------------------------
`default_nettype none

module bda_back (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire bda_pkg::queue_stat_t              stat_i,
  input  wire bda_pkg::char_item_t               rdata_i,
  output logic                                   pop_o,
  output logic                                   valid_o,
  output logic [bda_pkg::CharWidth-1:0]          character_o,
  output logic                                   last_o
);

  logic                          valid_q;
  logic [bda_pkg::CharWidth-1:0] character_q;
  logic                          last_q;

  assign pop_o = !stat_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      character_q <= rdata_i.character;
      last_q      <= rdata_i.last;
    end
  end

  assign valid_o     = valid_q;
  assign character_o = character_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

>>> src/binary_to_decimal_ascii.sv
// Flow: the front takes one subtraction or one digit step per cycle, a digit step
// waiting while the queue is full; each character is pushed into the queue, then
// popped and registered in the back, before it leaves on valid_o.
// Throughput: a new item is taken once the front is free; the back drains at one
// character per cycle; at QueueDepth above one the front is never held off.
// Reset: rst_ni is asynchronous and active low; no state is kept between items.
// ---------------------------------------------------------------------------
// binary_to_decimal_ascii
// Converts an unsigned 32-bit value into ASCII decimal digits, most
// significant first, with leading zeros suppressed.
// ---------------------------------------------------------------------------
`default_nettype none

module binary_to_decimal_ascii #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [bda_pkg::ValueWidth-1:0]    value_i,
  output logic                                   valid_o,
  output logic [bda_pkg::CharWidth-1:0]          character_o,
  output logic                                   last_o
);

  bda_pkg::queue_stat_t stat;
  bda_pkg::char_item_t  push_item;
  bda_pkg::char_item_t  pop_item;
  logic                 push;
  logic                 pop;

  bda_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .value_i (value_i),
    .stat_i  (stat),
    .push_o  (push),
    .item_o  (push_item)
  );

  bda_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_item),
    .pop_i   (pop),
    .rdata_o (pop_item),
    .stat_o  (stat)
  );

  bda_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stat_i      (stat),
    .rdata_i     (pop_item),
    .pop_o       (pop),
    .valid_o     (valid_o),
    .character_o (character_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

>>> src/bda_checker.sv
// ---------------------------------------------------------------------------
// bda_checker
// Port-level checks on the converter, attached to the top level by bind.
// ---------------------------------------------------------------------------
`default_nettype none

`include "binary_to_decimal_ascii_assert.svh"

module bda_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             start,
  input wire logic                             busy,
  input wire logic                             valid_o,
  input wire logic [bda_pkg::CharWidth-1:0]    character_o,
  input wire logic                             last_o
);

  `BDA_ASSERT_NEXT(a_accept_sets_busy, start && !busy, busy)
  `BDA_ASSERT_NOW(a_char_is_digit, valid_o, (character_o >= 6'd48) && (character_o <= 6'd57))
  `BDA_ASSERT_NEXT(a_units_follow_done, $fell(busy), valid_o && last_o)

endmodule

bind binary_to_decimal_ascii bda_checker u_bda_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .valid_o     (valid_o),
  .character_o (character_o),
  .last_o      (last_o)
);

`default_nettype wire
